FILE: rtl/aws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Apparent wind solver package
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aws_pkg;

  localparam int unsigned TabLen      = 24;
  localparam int unsigned StepsDef    = 16;
  localparam int unsigned ZW          = 26;  // angle word, 1/25600 degree
  localparam int unsigned CW          = 34;  // Q30 CORDIC word with headroom
  localparam int unsigned VW          = 36;  // Q8 vector component word
  localparam logic [CW-1:0] InvGainQ30 = CW'(652032875);
  localparam logic signed [ZW-1:0] RightAngleZ = ZW'(2304000);
  localparam logic [16:0] SpeedMax    = 17'd131070;

  typedef struct packed {
    logic signed [15:0] true_angle;
    logic [15:0]        true_speed;
    logic [15:0]        boat_speed;
    logic [15:0]        boat_heading;
  } req_t;

  typedef struct packed {
    logic [16:0]        apparent_speed;
    logic signed [15:0] apparent_angle;
    logic [15:0]        wind_bearing;
    logic               angle_undefined;
  } rsp_t;

  function automatic logic signed [ZW-1:0] atan_z(input int unsigned i);
    logic signed [ZW-1:0] t;
    begin
      case (i)
        0: t = ZW'(1152000);  1: t = ZW'(680065);  2: t = ZW'(359328);
        3: t = ZW'(182400);   4: t = ZW'(91554);   5: t = ZW'(45822);
        6: t = ZW'(22916);    7: t = ZW'(11459);   8: t = ZW'(5730);
        9: t = ZW'(2865);    10: t = ZW'(1432);   11: t = ZW'(716);
        12: t = ZW'(358);    13: t = ZW'(179);    14: t = ZW'(90);
        15: t = ZW'(45);     16: t = ZW'(22);     17: t = ZW'(11);
        18: t = ZW'(6);      19: t = ZW'(3);      20: t = ZW'(1);
        21: t = ZW'(1);
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/aws_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request / result channel interface
// Valid-ready channels that carry one payload each, of type req_t or rsp_t.
// ----------------------------------------------------------------------------
interface aws_req_if;
  import aws_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aws_rsp_if;
  import aws_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/aws_sqrt_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square root pipeline stage
// Resolves one result bit of a restoring integer square root per stage.
// ----------------------------------------------------------------------------
module aws_sqrt_stage #(
  parameter int unsigned RW = 38,
  parameter int unsigned BitPos = 0
) (
  input  wire logic [2*RW-1:0] rem_i,
  input  wire logic [RW-1:0]   root_i,
  output logic [2*RW-1:0]      rem_o,
  output logic [RW-1:0]        root_o
);
  logic [2*RW-1:0] trial;
  // One result bit per instance; the pipeline registers live outside.
  always_comb begin
    trial = ({{RW{1'b0}}, root_i} << (BitPos + 1)) | ((2*RW)'(1) << (2 * BitPos));
    if (rem_i >= trial) begin
      rem_o  = rem_i - trial;
      root_o = root_i | (RW'(1) << BitPos);
    end else begin
      rem_o  = rem_i;
      root_o = root_i;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/apparent_wind_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Apparent wind solver
// Combines true wind and vessel motion into apparent wind speed and angle.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; every stage is a register stage driven
// by a single pipeline-wide advance, so a stall freezes all stages at once.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module apparent_wind_solver #(
  parameter int unsigned CORDIC_STEPS = aws_pkg::StepsDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  aws_req_if.sink   req,
  aws_rsp_if.source rsp
);
  import aws_pkg::*;

  localparam int unsigned NS  = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int unsigned RW  = 38;       // root width for 76-bit radicand
  localparam int unsigned NSQ = RW;       // one root bit per stage

  // Pipeline advances when the output slot is free or being taken.
  logic adv;
  logic out_v_q;
  assign adv       = !out_v_q || rsp.ready;
  assign req.ready = adv;

  // ---------------- Stage A: angle reduction and bearing -------------------
  logic               a_v_q;
  logic signed [16:0] a_ang_q;
  logic [ZW-1:0]      a_z_q;
  logic               a_back_q;
  logic [15:0]        a_sp_q, a_bs_q, a_brg_q;
  logic signed [16:0] ang_w, mag_w, phi_w;
  logic [17:0]        brg_sum;
  logic [17:0]        brg_w;
  always_comb begin
    ang_w = 17'(req.data.true_angle);
    if (ang_w > 17'sd18000) ang_w = ang_w - 17'sd36000;
    else if (ang_w < -17'sd18000) ang_w = ang_w + 17'sd36000;
    mag_w = ang_w[16] ? -ang_w : ang_w;
    phi_w = (mag_w > 17'sd9000) ? 17'sd18000 - mag_w : mag_w;
    // ang + 36000 lies in 18000..54000; heading up to 65535.
    brg_sum = 18'(ang_w + 17'sd36000) ;
    brg_w   = 18'(brg_sum + 18'(req.data.boat_heading));
    if (brg_w >= 18'd108000) brg_w = brg_w - 18'd108000;
    else if (brg_w >= 18'd72000) brg_w = brg_w - 18'd72000;
    else if (brg_w >= 18'd36000) brg_w = brg_w - 18'd36000;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (adv) a_v_q <= req.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_ang_q  <= ang_w;
      a_z_q    <= ZW'(phi_w) << 8;
      a_back_q <= mag_w > 17'sd9000;
      a_sp_q   <= req.data.true_speed;
      a_bs_q   <= req.data.boat_speed;
      a_brg_q  <= brg_w[15:0];
    end
  end

  // ---------------- Rotation CORDIC, one step per stage ---------------------
  logic               r_v_q   [NS+1];
  logic signed [CW-1:0] r_x_q [NS+1];
  logic signed [CW-1:0] r_y_q [NS+1];
  logic signed [ZW-1:0] r_z_q [NS+1];
  logic signed [16:0] r_ang_q [NS+1];
  logic               r_bk_q  [NS+1];
  logic [15:0]        r_sp_q  [NS+1], r_bs_q [NS+1], r_brg_q [NS+1];

  always_comb begin
    r_v_q[0]   = a_v_q;
    r_x_q[0]   = InvGainQ30;
    r_y_q[0]   = '0;
    r_z_q[0]   = a_z_q;
    r_ang_q[0] = a_ang_q;
    r_bk_q[0]  = a_back_q;
    r_sp_q[0]  = a_sp_q;
    r_bs_q[0]  = a_bs_q;
    r_brg_q[0] = a_brg_q;
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) r_v_q[i+1] <= 1'b0;
      else if (adv) r_v_q[i+1] <= r_v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!r_z_q[i][ZW-1]) begin
          r_x_q[i+1] <= r_x_q[i] - (r_y_q[i] >>> i);
          r_y_q[i+1] <= r_y_q[i] + (r_x_q[i] >>> i);
          r_z_q[i+1] <= r_z_q[i] - atan_z(i);
        end else begin
          r_x_q[i+1] <= r_x_q[i] + (r_y_q[i] >>> i);
          r_y_q[i+1] <= r_y_q[i] - (r_x_q[i] >>> i);
          r_z_q[i+1] <= r_z_q[i] + atan_z(i);
        end
        r_ang_q[i+1] <= r_ang_q[i];
        r_bk_q[i+1]  <= r_bk_q[i];
        r_sp_q[i+1]  <= r_sp_q[i];
        r_bs_q[i+1]  <= r_bs_q[i];
        r_brg_q[i+1] <= r_brg_q[i];
      end
    end
  end

  // ---------------- Stage M: speed times cosine and sine --------------------
  logic                 m_v_q;
  logic signed [51:0]   m_xp_q, m_yp_q;
  logic [15:0]          m_bs_q, m_brg_q;
  logic signed [16:0]   m_ang_q;
  logic signed [CW-1:0] cos_w;
  assign cos_w = r_bk_q[NS] ? -r_x_q[NS] : r_x_q[NS];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else if (adv) m_v_q <= r_v_q[NS];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_xp_q  <= 52'($signed({1'b0, r_sp_q[NS]}) * cos_w);
      m_yp_q  <= 52'($signed({1'b0, r_sp_q[NS]}) * r_y_q[NS]);
      m_bs_q  <= r_bs_q[NS];
      m_ang_q <= r_ang_q[NS];
      m_brg_q <= r_brg_q[NS];
    end
  end

  // ---------------- Stage Q: add boat speed, round to Q8 --------------------
  logic                 q_v_q;
  logic signed [VW-1:0] q_bx_q, q_by_q;
  logic [15:0]          q_brg_q;
  logic signed [16:0]   q_ang_q;
  logic signed [52:0]   xq_w, yq_w;
  always_comb begin
    xq_w = 53'(m_xp_q) + (53'($unsigned(m_bs_q)) << 30) + 53'sd2097152;
    yq_w = (m_yp_q[51] ? 53'sd0 : 53'(m_yp_q)) + 53'sd2097152;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q_v_q <= 1'b0;
    else if (adv) q_v_q <= m_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_bx_q  <= VW'(xq_w >>> 22);
      q_by_q  <= VW'(yq_w >>> 22);
      q_ang_q <= m_ang_q;
      q_brg_q <= m_brg_q;
    end
  end

  // ---------------- Stage S: squares ---------------------------------------
  // |bx|,|by| < 2^25, so each square fits in 50 bits; the two squares come from
  // two 25x25 multiplies with a register in between them and their sum.
  logic                 s_v_q;
  logic [49:0]          s_xx_q, s_yy_q;
  logic signed [VW-1:0] s_bx_q, s_by_q;
  logic [15:0]          s_brg_q;
  logic signed [16:0]   s_ang_q;
  logic [24:0]          ax_w, ay_w;
  assign ax_w = q_bx_q[VW-1] ? 25'(-q_bx_q) : 25'(q_bx_q);
  assign ay_w = 25'(q_by_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_v_q <= 1'b0;
    else if (adv) s_v_q <= q_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_xx_q  <= 50'(ax_w) * 50'(ax_w);
      s_yy_q  <= 50'(ay_w) * 50'(ay_w);
      s_bx_q  <= q_bx_q;
      s_by_q  <= q_by_q;
      s_ang_q <= q_ang_q;
      s_brg_q <= q_brg_q;
    end
  end

  // ---------------- Square root, one root bit per stage ---------------------
  logic               t_v_q   [NSQ+1];
  logic [2*RW-1:0]    t_rem_q [NSQ+1];
  logic [RW-1:0]      t_root_q[NSQ+1];
  logic signed [VW-1:0] t_bx_q[NSQ+1], t_by_q [NSQ+1];
  logic signed [16:0] t_ang_q [NSQ+1];
  logic [15:0]        t_brg_q [NSQ+1];
  always_comb begin
    t_v_q[0]    = s_v_q;
    t_rem_q[0]  = (2*RW)'(s_xx_q) + (2*RW)'(s_yy_q);
    t_root_q[0] = '0;
    t_bx_q[0]   = s_bx_q;
    t_by_q[0]   = s_by_q;
    t_ang_q[0]  = s_ang_q;
    t_brg_q[0]  = s_brg_q;
  end
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [2*RW-1:0] rem_n;
    logic [RW-1:0]   root_n;
    aws_sqrt_stage #(.RW(RW), .BitPos(RW - 1 - k)) u_stage (
      .rem_i  (t_rem_q[k]),
      .root_i (t_root_q[k]),
      .rem_o  (rem_n),
      .root_o (root_n)
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) t_v_q[k+1] <= 1'b0;
      else if (adv) t_v_q[k+1] <= t_v_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        t_rem_q[k+1]  <= rem_n;
        t_root_q[k+1] <= root_n;
        t_bx_q[k+1]   <= t_bx_q[k];
        t_by_q[k+1]   <= t_by_q[k];
        t_ang_q[k+1]  <= t_ang_q[k];
        t_brg_q[k+1]  <= t_brg_q[k];
      end
    end
  end

  // ---------------- Stage P: speed rounding, vectoring preparation ---------
  logic                 p_v_q, p_zero_q;
  logic [16:0]          p_spd_q;
  logic signed [VW:0]   p_x_q, p_y_q;
  logic signed [ZW-1:0] p_z_q;
  logic signed [16:0]   p_ang_q;
  logic [15:0]          p_brg_q;
  logic [RW:0]          spd_w;
  always_comb begin
    spd_w = ((RW+1)'(t_root_q[NSQ]) + (RW+1)'(128)) >> 8;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_v_q <= 1'b0;
    else if (adv) p_v_q <= t_v_q[NSQ];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_spd_q  <= (spd_w > (RW+1)'(SpeedMax)) ? SpeedMax : spd_w[16:0];
      p_zero_q <= spd_w == '0;
      if (t_bx_q[NSQ][VW-1]) begin
        p_x_q <= (VW+1)'(t_by_q[NSQ]);
        p_y_q <= -(VW+1)'(t_bx_q[NSQ]);
        p_z_q <= RightAngleZ;
      end else begin
        p_x_q <= (VW+1)'(t_bx_q[NSQ]);
        p_y_q <= (VW+1)'(t_by_q[NSQ]);
        p_z_q <= '0;
      end
      p_ang_q <= t_ang_q[NSQ];
      p_brg_q <= t_brg_q[NSQ];
    end
  end

  // ---------------- Vectoring CORDIC, one step per stage --------------------
  localparam int unsigned XW = VW + 3;
  logic               v_v_q  [NS+1];
  logic signed [XW-1:0] v_x_q[NS+1], v_y_q [NS+1];
  logic signed [ZW-1:0] v_z_q[NS+1];
  logic               v_zero_q [NS+1];
  logic [16:0]        v_spd_q [NS+1];
  logic signed [16:0] v_ang_q [NS+1];
  logic [15:0]        v_brg_q [NS+1];
  always_comb begin
    v_v_q[0]    = p_v_q;
    v_x_q[0]    = XW'(p_x_q);
    v_y_q[0]    = XW'(p_y_q);
    v_z_q[0]    = p_z_q;
    v_zero_q[0] = p_zero_q;
    v_spd_q[0]  = p_spd_q;
    v_ang_q[0]  = p_ang_q;
    v_brg_q[0]  = p_brg_q;
  end
  for (genvar j = 0; j < NS; j++) begin : g_vec
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_v_q[j+1] <= 1'b0;
      else if (adv) v_v_q[j+1] <= v_v_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (v_y_q[j] > 0) begin
          v_x_q[j+1] <= v_x_q[j] + (v_y_q[j] >>> j);
          v_y_q[j+1] <= v_y_q[j] - (v_x_q[j] >>> j);
          v_z_q[j+1] <= v_z_q[j] + atan_z(j);
        end else begin
          v_x_q[j+1] <= v_x_q[j] - (v_y_q[j] >>> j);
          v_y_q[j+1] <= v_y_q[j] + (v_x_q[j] >>> j);
          v_z_q[j+1] <= v_z_q[j] - atan_z(j);
        end
        v_zero_q[j+1] <= v_zero_q[j];
        v_spd_q[j+1]  <= v_spd_q[j];
        v_ang_q[j+1]  <= v_ang_q[j];
        v_brg_q[j+1]  <= v_brg_q[j];
      end
    end
  end

  // ---------------- Output register: angle rounding and sign ---------------
  rsp_t                 out_q;
  logic signed [ZW-1:0] zr_w;
  logic signed [15:0]   mag_out_w;
  always_comb begin
    zr_w = (v_z_q[NS] + ZW'(128)) >>> 8;
    if (zr_w[ZW-1]) mag_out_w = '0;
    else if (zr_w > ZW'(18000)) mag_out_w = 16'sd18000;
    else mag_out_w = 16'(zr_w);
    if (v_zero_q[NS]) mag_out_w = '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= v_v_q[NS];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.apparent_speed  <= v_spd_q[NS];
      out_q.apparent_angle  <= v_ang_q[NS][16] ? -mag_out_w : mag_out_w;
      out_q.wind_bearing    <= v_brg_q[NS];
      out_q.angle_undefined <= v_zero_q[NS];
    end
  end

  assign rsp.valid = out_v_q;
  assign rsp.data  = out_q;

endmodule
`default_nettype wire

FILE: verif/apparent_wind_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Apparent wind solver testbench
// Drives sensor requests through the valid-ready request channel, predicts
// each apparent wind result with a bit-accurate fixed-point model and checks
// every returned result in order against it.
// ----------------------------------------------------------------------------
module apparent_wind_solver_tb;
  import aws_pkg::*;

  localparam int Steps      = 16;
  localparam int NumRandom  = 1330;
  localparam int IdleLimit  = 20000;
  localparam int Latency    = 2 * Steps + 44;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  aws_req_if req_ch ();
  aws_rsp_if rsp_ch ();

  apparent_wind_solver #(.CORDIC_STEPS(Steps)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source)
  );

  // Expected results, oldest first.
  rsp_t wind_expected_q[$];
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;

  // Arithmetic shift right; SystemVerilog >>> on signed longint floors.
  function automatic longint floor_shr(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint arctan_step(input int i);
    return longint'(atan_z(i));
  endfunction

  function automatic longint isqrt64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Bit-accurate prediction of one apparent wind result.
  function automatic rsp_t solve_apparent_wind(input req_t q);
    rsp_t   o;
    int     ang, mag, phi, hd, res_ang;
    bit     back;
    longint cx, sy, z, nx, xq, yq, bx, by, vx, vy, spd;
    int     n;
    n = (Steps > TabLen) ? TabLen : Steps;
    ang = int'(q.true_angle);
    if (ang > 18000) ang -= 36000;
    if (ang < -18000) ang += 36000;
    mag = (ang < 0) ? -ang : ang;
    phi = mag;
    back = 1'b0;
    if (phi > 9000) begin
      phi = 18000 - phi;
      back = 1'b1;
    end
    // Rotation CORDIC for cosine and sine in Q30.
    cx = 652032875;
    sy = 0;
    z = longint'(phi) * 256;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = cx - floor_shr(sy, i);
        sy = sy + floor_shr(cx, i);
        z -= arctan_step(i);
      end else begin
        nx = cx + floor_shr(sy, i);
        sy = sy - floor_shr(cx, i);
        z += arctan_step(i);
      end
      cx = nx;
    end
    if (back) cx = -cx;
    xq = longint'(q.true_speed) * cx + longint'(q.boat_speed) * (64'sd1 <<< 30);
    yq = longint'(q.true_speed) * sy;
    if (yq < 0) yq = 0;
    bx = floor_shr(xq + (64'sd1 <<< 21), 22);
    by = floor_shr(yq + (64'sd1 <<< 21), 22);
    spd = (isqrt64(longint'(bx * bx) + longint'(by * by)) + 128) >>> 8;
    if (spd > 131070) spd = 131070;
    res_ang = 0;
    o.angle_undefined = (spd == 0);
    if (spd != 0) begin
      // Vectoring CORDIC; the left half-plane is rotated by a right angle.
      if (bx < 0) begin
        vx = by;
        vy = -bx;
        z = 2304000;
      end else begin
        vx = bx;
        vy = by;
        z = 0;
      end
      for (int i = 0; i < n; i++) begin
        if (vy > 0) begin
          nx = vx + floor_shr(vy, i);
          vy = vy - floor_shr(vx, i);
          z += arctan_step(i);
        end else begin
          nx = vx - floor_shr(vy, i);
          vy = vy + floor_shr(vx, i);
          z -= arctan_step(i);
        end
        vx = nx;
      end
      z = floor_shr(z + 128, 8);
      if (z < 0) z = 0;
      if (z > 18000) z = 18000;
      res_ang = int'(z);
      if (ang < 0) res_ang = -res_ang;
    end
    hd = int'(q.boat_heading);
    o.apparent_speed = 17'(spd);
    o.apparent_angle = 16'(res_ang);
    o.wind_bearing = 16'((ang + 36000 + hd) % 36000);
    return o;
  endfunction

  // Directed table. A flag in each row says whether the typed-in result is
  // checked against the prediction as well; other rows rely on the model.
  typedef struct {
    req_t stim;
    bit   known;
    rsp_t gold;
  } wind_row_t;

  wind_row_t wind_table[$];

  function automatic req_t mk(input int a, input int ts, input int bs, input int hd);
    req_t r;
    r.true_angle = 16'(a);
    r.true_speed = 16'(ts);
    r.boat_speed = 16'(bs);
    r.boat_heading = 16'(hd);
    return r;
  endfunction

  function automatic rsp_t mkr(input int s, input int a, input int b, input bit f);
    rsp_t r;
    r.apparent_speed = 17'(s);
    r.apparent_angle = 16'(a);
    r.wind_bearing = 16'(b);
    r.angle_undefined = f;
    return r;
  endfunction

  task automatic add_row(input req_t s, input bit k, input rsp_t g);
    wind_row_t w;
    w.stim = s;
    w.known = k;
    w.gold = g;
    wind_table.push_back(w);
  endtask

  // Random request: mostly sensible sailing values, some full-range noise and some near-cancelling head winds.
  function automatic req_t random_request();
    req_t r;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      r.true_angle = 16'($urandom_range(0, 36000) - 18000);
      r.true_speed = 16'($urandom_range(0, 6000));
      r.boat_speed = 16'($urandom_range(0, 3000));
      r.boat_heading = 16'($urandom_range(0, 35999));
    end else if (sel < 8) begin
      r = req_t'({$urandom(), $urandom()});
    end else begin
      // Near-cancelling head wind keeps the zero-speed case alive.
      r.true_speed = 16'($urandom_range(0, 400));
      r.boat_speed = r.true_speed + 16'($urandom_range(0, 2)) - 16'd1;
      r.true_angle = 16'($urandom_range(0, 1) ? 18000 : -18000)
                     + 16'($urandom_range(0, 20)) - 16'd10;
      r.boat_heading = 16'($urandom());
    end
    return r;
  endfunction

  // Sends one request; the sender works in bursts with random idle gaps between them.
  int burst_left = 0;

  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    wind_expected_q.push_back(solve_apparent_wind(r));
    burst_left--;
  endtask

  // Request stimulus.
  initial begin
    req_t r;
    rsp_t p;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    // After reset: zero everything gives undefined angle and zero bearing.
    add_row(mk(0, 0, 0, 0), 1, mkr(0, 0, 0, 1));
    add_row(mk(0, 100, 0, 0), 1, mkr(100, 0, 0, 0));
    add_row(mk(0, 0, 65535, 35999), 1, mkr(65535, 0, 35999, 0));
    add_row(mk(0, 65535, 65535, 0), 0, '0);
    add_row(mk(18000, 65535, 0, 0), 0, '0);
    add_row(mk(-18000, 65535, 65535, 35999), 0, '0);
    add_row(mk(18000, 500, 500, 100), 0, '0);
    add_row(mk(-18000, 1, 1, 0), 0, '0);
    add_row(mk(9000, 1000, 1000, 9000), 0, '0);
    add_row(mk(-9000, 1000, 0, 0), 0, '0);
    add_row(mk(32767, 2000, 300, 0), 0, '0);       // above range, wraps
    add_row(mk(-32768, 2000, 300, 65535), 0, '0);  // below range, wraps
    add_row(mk(18001, 800, 200, 35999), 0, '0);
    add_row(mk(-18001, 800, 200, 0), 0, '0);
    add_row(mk(4500, 65535, 65535, 65535), 0, '0); // heading out of range
    add_row(mk(13500, 1200, 600, 20000), 0, '0);
    add_row(mk(-1, 1, 0, 1), 0, '0);
    add_row(mk(1, 0, 1, 0), 0, '0);
    add_row(mk(-13500, 1200, 1700, 30000), 0, '0);
    add_row(mk(17999, 10, 0, 12345), 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (wind_table[i]) begin
      if (wind_table[i].known) begin
        p = solve_apparent_wind(wind_table[i].stim);
        if (p != wind_table[i].gold) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("table row %0d: expected %p predicted %p",
                     i, wind_table[i].gold, p);
        end
      end
      send_request(wind_table[i].stim);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) begin
        // Let the pipeline drain completely before resuming.
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (wind_expected_q.size() != 0) @(posedge clk_i);
      end
      r = random_request();
      send_request(r);
    end
    req_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: stalls on a repeating pattern and at random, sometimes with long stretches open.
  int rsp_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      rsp_phase <= 0;
    end else begin
      rsp_phase <= rsp_phase + 1;
      if (rsp_phase[9]) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= (rsp_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (wind_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", rsp_ch.data);
      end else begin
        e = wind_expected_q.pop_front();
        if (rsp_ch.data.apparent_speed !== e.apparent_speed
            || rsp_ch.data.apparent_angle !== e.apparent_angle
            || rsp_ch.data.wind_bearing !== e.wind_bearing
            || rsp_ch.data.angle_undefined !== e.angle_undefined) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p got %p", e, rsp_ch.data);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no request or result is accepted.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("apparent_wind_solver test failed");
      $finish;
    end
  end

  // End of run: wait for every result, then the pipeline latency.
  initial begin
    wait (stim_done);
    while (wind_expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (mismatch_count == 0 && wind_expected_q.size() == 0) begin
      $display("apparent_wind_solver test passed");
    end else begin
      $display("apparent_wind_solver test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/aws_pkg.sv
rtl/aws_if.sv
rtl/aws_sqrt_stage.sv
rtl/apparent_wind_solver.sv
verif/apparent_wind_solver_tb.sv
